>>> rtl/pps_pkg.sv
// ============================================================================
// pps_pkg
// Shared types and constants for the preemptive priority scheduler: the job
// table row layout, request kinds, the sequencer states and the result word.
// ============================================================================
package pps_pkg;

  // Default table depth.
  localparam int MAX_PROCS_DEF = 16;

  // Field widths fixed by the stream format.
  localparam int TIME_W  = 32;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Request kinds carried on the input tuser.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // One row of the job table.
  typedef struct packed {
    logic               done;
    logic               started;
    logic [TIME_W-1:0]  start;
    logic [BURST_W-1:0] remain;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
  } row_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_REPORT
  } state_e;

  // One result word.
  typedef struct packed {
    logic              all_done;
    logic              finished;
    logic [TIME_W-1:0] wait_t;
    logic [TIME_W-1:0] turn_t;
    logic [TIME_W-1:0] fin_t;
    logic [TIME_W-1:0] start_t;
    logic [ID_W-1:0]   run_id;
    logic [TIME_W-1:0] slot_t;
  } result_t;

endpackage

>>> rtl/pps_ram.sv
// ============================================================================
// pps_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pps_cmp.sv
// ============================================================================
// pps_cmp
// Shared selection comparator: decides whether the table row under test
// replaces the best candidate found so far in the current scan.
// ============================================================================
module pps_cmp (
  input  pps_pkg::row_t                    cand_i,
  input  pps_pkg::row_t                    best_i,
  input  logic                             found_i,
  input  logic [pps_pkg::TIME_W-1:0]       now_i,
  output logic                             take_o
);
  import pps_pkg::*;

  logic eligible;
  logic better;

  // A job competes once it has arrived and is not yet complete.
  assign eligible = !cand_i.done && ({{(TIME_W-ARR_W){1'b0}}, cand_i.arrival} <= now_i);

  // Lower priority number wins, then earlier arrival; a full tie keeps the
  // earlier slot, since slots are scanned in ascending order.
  assign better = (cand_i.prio < best_i.prio) ||
                  ((cand_i.prio == best_i.prio) && (cand_i.arrival < best_i.arrival));

  assign take_o = eligible && (!found_i || better);

endmodule

>>> rtl/preemptive_priority_scheduler.sv
// ============================================================================
// preemptive_priority_scheduler
// Preemptive priority scheduler with a job table in RAM. An add word stores a
// job; a tick word serves the best ready job for one time unit and reports it.
// For a tick word, one table row per cycle is read through the single read
// port and checked by the shared comparator, followed by the drain, update
// and report states; the report state waits for the output to be free. The
// block accepts no word until the result is loaded. Reset clears the job and
// finish counts, the time and all handshake state; the table needs no
// clearing, as only rows below the job count are read.
// ============================================================================
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: job_arrival[15:0], job_burst[31:16], job_priority[39:32]
  input  logic [39:0]  s_axis_tdata,
  // tuser: req_type[0]
  input  logic         s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: slot_time[31:0], running_id[36:32], start_time[68:37],
  //        finish_time[100:69], turnaround_time[132:101],
  //        waiting_time[164:133], zero fill[167:165]
  output logic [167:0] m_axis_tdata,
  // tuser: job_finished[0]
  output logic         m_axis_tuser,
  // tlast: all_done
  output logic         m_axis_tlast
);
  import pps_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int SUM_W = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   job_cnt_q, job_cnt_d;
  logic [CNT_W-1:0]   fin_cnt_q, fin_cnt_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               found_q, found_d;
  row_t               best_q, best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic               fin_flag_q, fin_flag_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic [TIME_W-1:0]  fin_q, fin_d;
  logic [TIME_W-1:0]  turn_q, turn_d;
  logic               out_vld_q, out_vld_d;
  result_t            out_q, out_d;

  logic               in_acc;
  logic               out_free;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  row_t               ram_wdata;
  row_t               ram_rdata;
  logic               take;
  logic [BURST_W-1:0] rem_new;
  logic [TIME_W-1:0]  fin_val;
  logic [TIME_W-1:0]  burst_ext;
  logic [TIME_W-1:0]  wait_val;
  logic [SUM_W-1:0]   id_sum;
  logic [CNT_W-1:0]   fin_cnt_new;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // Job table.
  pps_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shared comparator.
  pps_cmp u_cmp (
    .cand_i  (ram_rdata),
    .best_i  (best_q),
    .found_i (found_q),
    .now_i   (now_q),
    .take_o  (take)
  );

  // Arithmetic helpers for the update and report steps.
  assign rem_new     = best_q.remain - BURST_W'(1);
  assign fin_val     = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);
  assign burst_ext   = {{(TIME_W-BURST_W){1'b0}}, best_q.burst};
  assign wait_val    = (turn_q >= burst_ext) ? turn_q - burst_ext : '0;
  assign id_sum      = SUM_W'(best_idx_q) + SUM_W'(1);
  assign fin_cnt_new = fin_cnt_q + CNT_W'(fin_flag_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == REQ_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == job_cnt_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_REPORT;
      ST_REPORT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    cnt_d         = cnt_q;
    job_cnt_d     = job_cnt_q;
    fin_cnt_d     = fin_cnt_q;
    now_d         = now_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cnt_q[IDX_W-1:0];
    found_d       = found_q;
    best_d        = best_q;
    best_idx_d    = best_idx_q;
    fin_flag_d    = fin_flag_q;
    start_d       = start_q;
    fin_d         = fin_q;
    turn_d        = turn_q;
    out_d         = out_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    ram_we        = 1'b0;
    ram_waddr     = job_cnt_q[IDX_W-1:0];
    ram_wdata     = '0;

    // Track the best candidate whenever a table row is on the read port.
    if (cmp_vld_q && take) begin
      best_d     = ram_rdata;
      best_idx_d = cmp_idx_q;
      found_d    = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_d         = '0;
        found_d       = 1'b0;
        // An add word fills the next free row unless the table is full or
        // the burst is empty.
        if (in_acc && (s_axis_tuser == REQ_ADD) &&
            (job_cnt_q != CNT_W'(MAX_PROCS)) && (s_axis_tdata[31:16] != '0)) begin
          ram_we            = 1'b1;
          ram_wdata.arrival = s_axis_tdata[15:0];
          ram_wdata.burst   = s_axis_tdata[31:16];
          ram_wdata.remain  = s_axis_tdata[31:16];
          ram_wdata.prio    = s_axis_tdata[39:32];
          job_cnt_d         = job_cnt_q + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        // Issue one row read per cycle.
        if (cnt_q != job_cnt_q) begin
          cmp_vld_d = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        // Serve the chosen job for one tick and write its row back.
        fin_flag_d = found_q && (rem_new == '0);
        start_d    = best_q.started ? best_q.start : now_q;
        fin_d      = fin_val;
        turn_d     = fin_val - {{(TIME_W-ARR_W){1'b0}}, best_q.arrival};
        if (found_q) begin
          ram_we            = 1'b1;
          ram_waddr         = best_idx_q;
          ram_wdata         = best_q;
          ram_wdata.remain  = rem_new;
          ram_wdata.started = 1'b1;
          ram_wdata.start   = best_q.started ? best_q.start : now_q;
          ram_wdata.done    = (rem_new == '0);
        end
      end
      ST_REPORT: begin
        // Load the result word and advance time.
        if (out_free) begin
          out_vld_d      = 1'b1;
          out_d          = '0;
          out_d.slot_t   = now_q;
          out_d.run_id   = found_q ? id_sum[ID_W-1:0] : '0;
          out_d.finished = fin_flag_q;
          out_d.all_done = (fin_cnt_new == job_cnt_q);
          if (fin_flag_q) begin
            out_d.start_t = start_q;
            out_d.fin_t   = fin_q;
            out_d.turn_t  = turn_q;
            out_d.wait_t  = wait_val;
          end
          fin_cnt_d = fin_cnt_new;
          now_d     = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      job_cnt_q <= '0;
      fin_cnt_q <= '0;
      now_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      job_cnt_q <= job_cnt_d;
      fin_cnt_q <= fin_cnt_d;
      now_q     <= now_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    fin_flag_q <= fin_flag_d;
    start_q    <= start_d;
    fin_q      <= fin_d;
    turn_q     <= turn_d;
    out_q      <= out_d;
  end

  // Output stream.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.finished;
  assign m_axis_tlast  = out_q.all_done;
  assign m_axis_tdata  = {3'b000, out_q.wait_t, out_q.turn_t, out_q.fin_t,
                          out_q.start_t, out_q.run_id, out_q.slot_t};

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Scheduler stream testbench
// Drives add and tick words into the preemptive priority scheduler and checks
// every tick report against a local job-table model or a fixed report. A short
// directed table covers the empty-table tick, refused adds, priority and
// arrival ties, late adds and preemption. A long random run follows, with
// bursty back-pressure on both streams. It fills the table, keeps adding once
// the table is full, and loads a final job that never arrives.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int MAX_JOBS     = MAX_PROCS_DEF;
  localparam int RAND_ITEMS   = 1200;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_LIMIT  = 200;

  // One tick report, split into its fields.
  typedef struct packed {
    logic [31:0] slot_t;
    logic [4:0]  run_id;
    logic        finished;
    logic [31:0] start_t;
    logic [31:0] fin_t;
    logic [31:0] turn_t;
    logic [31:0] wait_t;
    logic        all_done;
  } tick_report_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic         kind;
    logic [39:0]  data;
    bit           fixed;
    tick_report_t report;
  } plan_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: job_arrival[15:0], job_burst[31:16], job_priority[39:32]
  logic [39:0]  s_axis_tdata = '0;
  // tuser: req_type[0]
  logic         s_axis_tuser = REQ_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: slot_time[31:0], running_id[36:32], start_time[68:37],
  //        finish_time[100:69], turnaround_time[132:101],
  //        waiting_time[164:133], zero fill[167:165]
  logic [167:0] m_axis_tdata;
  // tuser: job_finished[0]
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  // Job table model.
  logic [15:0]  job_arr   [MAX_JOBS];
  logic [15:0]  job_burst [MAX_JOBS];
  logic [7:0]   job_prio  [MAX_JOBS];
  logic [15:0]  job_left  [MAX_JOBS];
  logic [31:0]  job_start [MAX_JOBS];
  bit           job_started [MAX_JOBS];
  bit           job_done    [MAX_JOBS];
  int           jobs_loaded = 0;
  int           jobs_finished = 0;
  logic [31:0]  sched_now = '0;

  tick_report_t pending_reports[$];
  plan_row_t    plan[$];
  int           errors = 0;
  int           words_sent = 0;
  int           reports_seen = 0;
  int           hold_left = 0;
  bit           held_once = 1'b0;

  preemptive_priority_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Update the job table for one word and work out the report of a tick.
  task automatic apply_request(input logic kind, input logic [39:0] data,
                               output bit has_report, output bit took_effect,
                               output tick_report_t rep);
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [31:0] t;
    logic [31:0] fin;
    logic [31:0] turn;
    int          best;
    bit          found;
    arr   = data[15:0];
    burst = data[31:16];
    prio  = data[39:32];
    rep   = '0;
    has_report  = 1'b0;
    took_effect = 1'b0;
    best  = 0;
    found = 1'b0;
    if (kind == REQ_ADD) begin
      // A full table or a zero burst leaves the table untouched.
      if (jobs_loaded < MAX_JOBS && burst != 16'd0) begin
        job_arr[jobs_loaded]     = arr;
        job_burst[jobs_loaded]   = burst;
        job_prio[jobs_loaded]    = prio;
        job_left[jobs_loaded]    = burst;
        job_started[jobs_loaded] = 1'b0;
        job_done[jobs_loaded]    = 1'b0;
        jobs_loaded++;
        took_effect = 1'b1;
      end
      return;
    end
    has_report  = 1'b1;
    took_effect = 1'b1;
    t = sched_now;
    // Lowest priority number wins, then earlier arrival, then lower slot.
    for (int i = 0; i < jobs_loaded; i++) begin
      if (job_done[i] || {16'd0, job_arr[i]} > t) continue;
      if (!found || job_prio[i] < job_prio[best] ||
          (job_prio[i] == job_prio[best] && job_arr[i] < job_arr[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    rep.slot_t = t;
    if (found) begin
      rep.run_id = 5'(best + 1);
      if (!job_started[best]) begin
        job_started[best] = 1'b1;
        job_start[best]   = t;
      end
      job_left[best] = job_left[best] - 16'd1;
      if (job_left[best] == 16'd0) begin
        fin  = (t == TIME_MAX) ? TIME_MAX : t + 32'd1;
        turn = fin - {16'd0, job_arr[best]};
        job_done[best] = 1'b1;
        jobs_finished++;
        rep.finished = 1'b1;
        rep.start_t  = job_start[best];
        rep.fin_t    = fin;
        rep.turn_t   = turn;
        rep.wait_t   = (turn >= {16'd0, job_burst[best]}) ?
                       turn - {16'd0, job_burst[best]} : 32'd0;
      end
    end
    rep.all_done = (jobs_finished == jobs_loaded);
    if (sched_now != TIME_MAX) sched_now = sched_now + 32'd1;
  endtask

  // Offer one word, at times after a random gap, and wait for its handshake.
  task automatic offer_word(input logic kind, input logic [39:0] data);
    bit may_idle;
    may_idle = (words_sent < 600 || words_sent >= 800);
    if (may_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    words_sent++;
  endtask

  // Send a word and queue the report it is due to produce.
  task automatic issue(input logic kind, input logic [39:0] data, input bit fixed,
                       input tick_report_t fixed_rep, output bit took_effect);
    bit           has_report;
    tick_report_t rep;
    offer_word(kind, data);
    apply_request(kind, data, has_report, took_effect, rep);
    if (has_report)
      pending_reports.insert(pending_reports.size(), fixed ? fixed_rep : rep);
  endtask

  // Append one row to the directed table.
  task automatic plan_append(input plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  function automatic plan_row_t add_row(input logic [15:0] arr, input logic [15:0] burst,
                                        input logic [7:0] prio);
    plan_row_t row;
    row.kind   = REQ_ADD;
    row.data   = {prio, burst, arr};
    row.fixed  = 1'b0;
    row.report = '0;
    return row;
  endfunction

  function automatic plan_row_t tick_row(input logic [39:0] data, input bit fixed,
                                         input tick_report_t rep);
    plan_row_t row;
    row.kind   = REQ_TICK;
    row.data   = data;
    row.fixed  = fixed;
    row.report = rep;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, name, exp_v, act_v);
    end
  endtask

  // Compare one received word with the oldest pending report.
  task automatic check_report();
    tick_report_t got;
    tick_report_t exp_r;
    got.slot_t   = m_axis_tdata[31:0];
    got.run_id   = m_axis_tdata[36:32];
    got.start_t  = m_axis_tdata[68:37];
    got.fin_t    = m_axis_tdata[100:69];
    got.turn_t   = m_axis_tdata[132:101];
    got.wait_t   = m_axis_tdata[164:133];
    got.finished = m_axis_tuser;
    got.all_done = m_axis_tlast;
    if (pending_reports.size() == 0) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t ns: unexpected report, expected none, actual slot %0d id %0d",
                 $time, got.slot_t, got.run_id);
      return;
    end
    exp_r = pending_reports.pop_front();
    check_field("slot_time", exp_r.slot_t, got.slot_t);
    check_field("running_id", 32'(exp_r.run_id), 32'(got.run_id));
    check_field("job_finished", 32'(exp_r.finished), 32'(got.finished));
    check_field("start_time", exp_r.start_t, got.start_t);
    check_field("finish_time", exp_r.fin_t, got.fin_t);
    check_field("turnaround_time", exp_r.turn_t, got.turn_t);
    check_field("waiting_time", exp_r.wait_t, got.wait_t);
    check_field("all_done", 32'(exp_r.all_done), 32'(got.all_done));
  endtask

  // Report side: check each word, then pick tready for the next cycle.
  // One long hold-off lets the block fill up and stall its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        check_report();
        reports_seen++;
      end
      if (!held_once && reports_seen == 300) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (reports_seen >= 700 && reports_seen < 900) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // Watchdog on cycles in which neither stream moves a word.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    plan_row_t    row;
    tick_report_t rep;
    bit           took;
    int           busy;
    int           pick;
    logic [31:0]  arr_w;
    logic [15:0]  burst;
    logic [7:0]   prio;
    logic [39:0]  data;

    // Empty table: the tick is idle and everything counts as done.
    rep = '0;
    rep.all_done = 1'b1;
    plan_append(tick_row('1, 1'b1, rep));
    // Zero bursts are refused.
    plan_append(add_row(16'hFFFF, 16'd0, 8'hFF));
    plan_append(add_row(16'd0, 16'd0, 8'd0));
    // A one-tick job runs at tick 1 and finishes at 2.
    plan_append(add_row(16'd0, 16'd1, 8'd0));
    rep = '0;
    rep.slot_t   = 32'd1;
    rep.run_id   = 5'd1;
    rep.finished = 1'b1;
    rep.start_t  = 32'd1;
    rep.fin_t    = 32'd2;
    rep.turn_t   = 32'd2;
    rep.wait_t   = 32'd1;
    rep.all_done = 1'b1;
    plan_append(tick_row('0, 1'b1, rep));
    rep = '0;
    rep.slot_t   = 32'd2;
    rep.all_done = 1'b1;
    plan_append(tick_row('0, 1'b1, rep));
    // Equal priority: same arrival goes to the lower slot, and a late add
    // with an earlier arrival wins over both.
    plan_append(add_row(16'd3, 16'd2, 8'd7));
    plan_append(add_row(16'd3, 16'd2, 8'd7));
    plan_append(add_row(16'd2, 16'd1, 8'd7));
    plan_append(tick_row('0, 1'b0, '0));
    plan_append(tick_row('0, 1'b0, '0));
    // Lowest urgency, and an urgent job that preempts once it arrives.
    plan_append(add_row(16'd4, 16'd3, 8'hFF));
    plan_append(add_row(16'd6, 16'd1, 8'd0));
    repeat (9) plan_append(tick_row('0, 1'b0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      issue(row.kind, row.data, row.fixed, row.report, took);
    end

    // Random run: mostly ticks, with sparse adds so the table fills late.
    busy = 0;
    while (busy < RAND_ITEMS) begin
      pick = $urandom_range(199);
      if (pick < 5) begin
        if ($urandom_range(4) < 2)
          arr_w = sched_now - $urandom_range(sched_now, 0);
        else
          arr_w = sched_now + $urandom_range(60, 0);
        if (arr_w > 32'hFFFF) arr_w = 32'hFFFF;
        burst = ($urandom_range(9) == 0) ? 16'($urandom_range(400, 1)) :
                                           16'($urandom_range(40, 1));
        prio  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        if (pick == 0) begin
          burst = 16'd0;
        end else if (jobs_loaded == MAX_JOBS - 1) begin
          // Last slot: a job that never arrives and never runs.
          arr_w = 32'hFFFF;
          burst = 16'hFFFF;
          prio  = 8'hFF;
        end
        data = {prio, burst, arr_w[15:0]};
        issue(REQ_ADD, data, 1'b0, '0, took);
      end else begin
        data[31:0]  = $urandom;
        data[39:32] = 8'($urandom_range(255));
        issue(REQ_TICK, data, 1'b0, '0, took);
      end
      if (took) busy++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
